>>> src/fbf_pkg.sv
// Package: shared constants, codes and controller/datapath handshake types.
package fbf_pkg;

    // Field widths
    localparam int ID_W    = 3;
    localparam int FRAME_W = 16;
    localparam int PKT_W   = 16;
    localparam int BYTE_W  = 32;

    // Divider geometry: 40-bit dividend, 16-bit divisor
    localparam int DIV_W = 40;
    localparam int DEN_W = 16;

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_FPS  = 2'd1;
    localparam logic [1:0] REG_MIN  = 2'd2;
    localparam logic [1:0] REG_ACT  = 2'd3;

    // Policy modes
    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_SOLVER = 2'd1;
    localparam logic [1:0] MODE_FIXED  = 2'd2;
    localparam logic [1:0] MODE_CAP    = 2'd3;

    // Divider operand selects
    localparam logic [1:0] DIV_RATE = 2'd0;
    localparam logic [1:0] DIV_CC   = 2'd1;
    localparam logic [1:0] DIV_CAP  = 2'd2;

    // Target kinds for one destination
    localparam logic [1:0] TGT_CONST = 2'd0;
    localparam logic [1:0] TGT_RATE  = 2'd1;
    localparam logic [1:0] TGT_FAIR  = 2'd2;
    localparam logic [1:0] TGT_BOTH  = 2'd3;

    // Constants and reset values
    localparam logic [31:0] PLAIN_TARGET  = 32'd1000000;
    localparam logic [31:0] RST_CC        = 32'd62500;
    localparam logic [31:0] RST_CAPACITY  = 32'd10000000;
    localparam logic [31:0] RST_RATE      = 32'd256;
    localparam logic [7:0]  RST_FPS       = 8'd20;
    localparam logic [31:0] RST_MIN       = 32'd1000;
    localparam logic [3:0]  RST_ACTIVE    = 4'd8;

    typedef struct packed {
        logic       clr_step;
        logic       in_load;
        logic       upd_wr;
        logic       d_first;
        logic       mem_rd;
        logic       mul_en;
        logic       div_start;
        logic [1:0] div_sel;
        logic       save_fair;
        logic       tgt_load;
        logic       decide;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       is_upd;
        logic       pkt_go;
        logic [1:0] tsel;
        logic       eq;
        logic       div_done;
        logic       out_free;
        logic       last_d;
    } stat_t;

endpackage

>>> src/fbf_in_if.sv
// Input channel: one packet or client-update word.
interface fbf_in_if;
    import fbf_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [ID_W-1:0]     client_id;
    logic [FRAME_W-1:0]  frame_num;
    logic [PKT_W-1:0]    packet_bytes;
    logic [BYTE_W-1:0]   cc_frame_bytes;
    logic [BYTE_W-1:0]   capacity_frame_bytes;
    logic                constrained;
    logic [BYTE_W-1:0]   downlink_rate_q8;

    modport source (output valid, kind, client_id, frame_num, packet_bytes, cc_frame_bytes,
                    capacity_frame_bytes, constrained, downlink_rate_q8, input ready);
    modport sink   (input valid, kind, client_id, frame_num, packet_bytes, cc_frame_bytes,
                    capacity_frame_bytes, constrained, downlink_rate_q8, output ready);
endinterface

>>> src/fbf_out_if.sv
// Output channel: one forward/drop decision word.
interface fbf_out_if;
    import fbf_pkg::*;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] dest_id;
    logic            forward;
    logic            last;

    modport source (output valid, dest_id, forward, last, input ready);
    modport sink   (input valid, dest_id, forward, last, output ready);
endinterface

>>> src/fbf_div.sv
// Restoring divider, one quotient bit per cycle.
module fbf_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fbf_pkg::DIV_W-1:0] dividend,
    input  logic [fbf_pkg::DEN_W-1:0] divisor,
    output logic [fbf_pkg::DIV_W-1:0] quotient,
    output logic                      done
);
    import fbf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    // shift in next dividend bit and trial subtract
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DIV_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

>>> src/fbf_dp.sv
// Datapath: pair memory, client tables, target arithmetic and result register.
module fbf_dp #(
    parameter int MAX_CLIENTS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  fbf_pkg::cmd_t                cmd,
    output fbf_pkg::stat_t               stat,
    input  logic [1:0]                   cfg_mode,
    input  logic [7:0]                   cfg_fps,
    input  logic [fbf_pkg::BYTE_W-1:0]   cfg_min,
    input  logic [3:0]                   cfg_active,
    input  logic                         in_kind,
    input  logic [fbf_pkg::ID_W-1:0]     in_client_id,
    input  logic [fbf_pkg::FRAME_W-1:0]  in_frame_num,
    input  logic [fbf_pkg::PKT_W-1:0]    in_packet_bytes,
    input  logic [fbf_pkg::BYTE_W-1:0]   in_cc_frame_bytes,
    input  logic [fbf_pkg::BYTE_W-1:0]   in_capacity_frame_bytes,
    input  logic                         in_constrained,
    input  logic [fbf_pkg::BYTE_W-1:0]   in_downlink_rate_q8,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [fbf_pkg::ID_W-1:0]     out_dest_id,
    output logic                         out_forward,
    output logic                         out_last
);
    import fbf_pkg::*;

    localparam int IW    = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int DW    = $clog2(MAX_CLIENTS + 1) + 1;
    localparam int CW    = DW + 4;
    localparam int DEPTH = MAX_CLIENTS * MAX_CLIENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = FRAME_W + BYTE_W;

    // client tables
    logic [BYTE_W-1:0] cc_tab   [MAX_CLIENTS];
    logic [BYTE_W-1:0] cap_tab  [MAX_CLIENTS];
    logic [BYTE_W-1:0] rate_tab [MAX_CLIENTS];
    logic              con_tab  [MAX_CLIENTS];

    // pair memory
    logic [EW-1:0]     mem [DEPTH];
    logic [EW-1:0]     rd_reg;

    logic [ID_W-1:0]    src_reg;
    logic [FRAME_W-1:0] fid_reg;
    logic [PKT_W-1:0]   pkt_reg;
    logic [DW-1:0]      d_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [BYTE_W-1:0]  fair_reg;
    logic [63:0]        prod_reg;
    logic [BYTE_W-1:0]  tgt_reg;
    logic               out_valid_reg;
    logic [ID_W-1:0]    out_dest_reg;
    logic               out_fwd_reg;
    logic               out_last_reg;

    logic [DW-1:0]      n_w;
    logic [DW-1:0]      first_d;
    logic [DW-1:0]      nd1;
    logic [DW-1:0]      nd;
    logic [IW-1:0]      d_idx;
    logic               upd_ok;
    logic [AW-1:0]      addr;
    logic [BYTE_W-1:0]  cc_d;
    logic [BYTE_W-1:0]  cap_d;
    logic [BYTE_W-1:0]  rate_d;
    logic               con_d;
    logic [1:0]         tsel;
    logic [7:0]         fps_eff;
    logic [DEN_W-1:0]   den;
    logic [56:0]        c_w;
    logic [BYTE_W-1:0]  cap_sat;
    logic [DIV_W-1:0]   div_dividend;
    logic [DEN_W-1:0]   div_divisor;
    logic [DIV_W-1:0]   div_quo;
    logic               div_done;
    logic [BYTE_W-1:0]  q32;
    logic [BYTE_W-1:0]  both_min;
    logic [BYTE_W-1:0]  tgt_raw;
    logic [BYTE_W-1:0]  tgt_floor;
    logic [FRAME_W-1:0] rd_frame;
    logic [BYTE_W-1:0]  rd_bytes;
    logic               eq;
    logic               gt;
    logic               fwd;
    logic [BYTE_W:0]    sum;
    logic [BYTE_W-1:0]  sum_sat;
    logic [EW-1:0]      new_entry;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [EW-1:0]      mem_wd;

    // active count and destination walk
    always_comb
    begin
        n_w     = (CW'(cfg_active) > CW'(MAX_CLIENTS)) ? DW'(MAX_CLIENTS) : DW'(cfg_active);
        first_d = (in_client_id == '0) ? DW'(1) : DW'(0);
        nd1     = d_reg + DW'(1);
        nd      = (nd1 == DW'(src_reg)) ? d_reg + DW'(2) : nd1;
        upd_ok  = CW'(in_client_id) < CW'(MAX_CLIENTS);
        d_idx   = d_reg[IW-1:0];
        addr    = AW'(src_reg) * AW'(MAX_CLIENTS) + AW'(d_idx);
    end

    // per-destination table reads
    always_comb
    begin
        cc_d   = cc_tab[d_idx];
        cap_d  = cap_tab[d_idx];
        rate_d = rate_tab[d_idx];
        con_d  = con_tab[d_idx];
    end

    // which target formula applies
    always_comb
    begin
        case (cfg_mode)
            MODE_SOLVER, MODE_FIXED: tsel = con_d ? TGT_RATE : TGT_CONST;
            MODE_CAP:                tsel = con_d ? TGT_BOTH : TGT_FAIR;
            default:                 tsel = TGT_CONST;
        endcase
    end

    // divider operands
    always_comb
    begin
        fps_eff = (cfg_fps == 8'd0) ? 8'd1 : cfg_fps;
        den     = {fps_eff, 8'h00};
        c_w     = 57'(prod_reg[63:8]) + 57'(|prod_reg[7:0]);
        cap_sat = (|c_w[56:32]) ? '1 : c_w[31:0];
        case (cmd.div_sel)
            DIV_RATE: div_dividend = DIV_W'(rate_d) * DIV_W'(125) + DIV_W'(den) - DIV_W'(1);
            DIV_CC:   div_dividend = DIV_W'(cc_d);
            DIV_CAP:  div_dividend = DIV_W'(cap_sat);
            default:  div_dividend = DIV_W'(cc_d);
        endcase
        div_divisor = (cmd.div_sel == DIV_RATE) ? den : DEN_W'(n_w - DW'(1));
    end

    fbf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    // target frame size
    always_comb
    begin
        q32      = div_quo[BYTE_W-1:0];
        both_min = (fair_reg < q32) ? fair_reg : q32;
        case (tsel)
            TGT_RATE: tgt_raw = q32;
            TGT_FAIR: tgt_raw = fair_reg;
            TGT_BOTH: tgt_raw = both_min;
            default:  tgt_raw = PLAIN_TARGET;
        endcase
        tgt_floor = (tsel == TGT_CONST || tgt_raw > cfg_min) ? tgt_raw : cfg_min;
    end

    // forward decision and pair update
    always_comb
    begin
        rd_frame  = rd_reg[EW-1:BYTE_W];
        rd_bytes  = rd_reg[BYTE_W-1:0];
        eq        = (fid_reg == rd_frame);
        gt        = (fid_reg > rd_frame);
        fwd       = gt || (eq && (rd_bytes < tgt_reg));
        sum       = (BYTE_W+1)'(rd_bytes) + (BYTE_W+1)'(pkt_reg);
        sum_sat   = sum[BYTE_W] ? '1 : sum[BYTE_W-1:0];
        new_entry = gt ? {fid_reg, BYTE_W'(pkt_reg)} : {rd_frame, sum_sat};
        mem_we    = cmd.clr_step || (cmd.decide && fwd);
        mem_wa    = cmd.clr_step ? clr_cnt_reg : addr;
        mem_wd    = cmd.clr_step ? '0 : new_entry;
    end

    // pair memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (cmd.mem_rd)
            rd_reg <= mem[addr];
    end

    // client tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLIENTS; i++)
            begin
                cc_tab[i]   <= RST_CC;
                cap_tab[i]  <= RST_CAPACITY;
                rate_tab[i] <= RST_RATE;
                con_tab[i]  <= 1'b0;
            end
        end
        else if (cmd.upd_wr && upd_ok)
        begin
            cc_tab[IW'(in_client_id)]   <= in_cc_frame_bytes;
            cap_tab[IW'(in_client_id)]  <= in_capacity_frame_bytes;
            rate_tab[IW'(in_client_id)] <= in_downlink_rate_q8;
            con_tab[IW'(in_client_id)]  <= in_constrained;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            d_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.d_first)
                d_reg <= first_d;
            else if (cmd.decide)
                d_reg <= nd;
            if (cmd.decide)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            src_reg <= in_client_id;
            fid_reg <= in_frame_num;
            pkt_reg <= in_packet_bytes;
        end
        if (cmd.mul_en)
            prod_reg <= 64'(cap_d) * 64'(rate_d);
        if (cmd.save_fair)
            fair_reg <= q32;
        if (cmd.tgt_load)
            tgt_reg <= tgt_floor;
        if (cmd.decide)
        begin
            out_dest_reg <= ID_W'(d_reg);
            out_fwd_reg  <= fwd;
            out_last_reg <= !(nd < n_w);
        end
    end

    // status to controller
    always_comb
    begin
        stat.clr_last = (clr_cnt_reg == AW'(DEPTH - 1));
        stat.is_upd   = in_kind;
        stat.pkt_go   = !in_kind && (DW'(in_client_id) < n_w) && (first_d < n_w);
        stat.tsel     = tsel;
        stat.eq       = eq;
        stat.div_done = div_done;
        stat.out_free = !out_valid_reg || out_ready;
        stat.last_d   = !(nd < n_w);
    end

    assign out_valid   = out_valid_reg;
    assign out_dest_id = out_dest_reg;
    assign out_forward = out_fwd_reg;
    assign out_last    = out_last_reg;
endmodule

>>> src/fbf_ctrl.sv
// Controller: sequences clearing, item intake and the per-destination walk.
module fbf_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fbf_pkg::stat_t stat,
    output fbf_pkg::cmd_t  cmd
);
    import fbf_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_DIVF = 4'd4;
    localparam logic [3:0] S_DIVT = 4'd5;
    localparam logic [3:0] S_TGT  = 4'd6;
    localparam logic [3:0] S_DEC  = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    if (stat.is_upd)
                        cmd.upd_wr = 1'b1;
                    else if (stat.pkt_go)
                    begin
                        cmd.d_first = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.mul_en = 1'b1;
                if (!stat.eq)
                    state_next = S_DEC;
                else
                begin
                    case (stat.tsel)
                        TGT_RATE:
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = DIV_RATE;
                            state_next    = S_DIVT;
                        end
                        TGT_FAIR, TGT_BOTH:
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = DIV_CC;
                            state_next    = S_DIVF;
                        end
                        default: state_next = S_TGT;
                    endcase
                end
            end
            S_DIVF:
            begin
                if (stat.div_done)
                begin
                    cmd.save_fair = 1'b1;
                    if (stat.tsel == TGT_BOTH)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_CAP;
                        state_next    = S_DIVT;
                    end
                    else
                        state_next = S_TGT;
                end
            end
            S_DIVT:
            begin
                if (stat.div_done)
                    state_next = S_TGT;
            end
            S_TGT:
            begin
                cmd.tgt_load = 1'b1;
                state_next   = S_DEC;
            end
            S_DEC:
            begin
                if (stat.out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = stat.last_d ? S_IDLE : S_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end
endmodule

>>> src/frame_budget_forward_filter_unit.sv
// Top level: configuration registers, controller and datapath.
//
// Each packet word is checked against every other active client in ascending id
// order and yields one decision word per destination. A destination passes
// through memory read, compare and decide when the frame id differs from the
// stored one. When it is the same, a target step comes before the decision,
// and before that one pass of the shared bit-serial divider when the target
// needs it (rate or fair share), or two divider passes in capacity-limited mode
// for a constrained destination. The receiver may stall a decision word; the
// divider is the dominant unit. Update words give no output. After reset the
// pair memory is cleared one entry per cycle, all MAX_CLIENTS*MAX_CLIENTS
// entries, while no input word is accepted.
module frame_budget_forward_filter_unit #(
    parameter int MAX_CLIENTS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    fbf_in_if.sink                      in_ch,
    fbf_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbf_pkg::APB_AW-1:0]  paddr,
    input  logic [fbf_pkg::APB_DW-1:0]  pwdata,
    output logic [fbf_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import fbf_pkg::*;

    logic [1:0]  mode_reg;
    logic [7:0]  fps_reg;
    logic [31:0] min_reg;
    logic [3:0]  active_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    cmd_t  cmd;
    stat_t stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PLAIN;
            fps_reg    <= RST_FPS;
            min_reg    <= RST_MIN;
            active_reg <= RST_ACTIVE;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MODE: mode_reg   <= pwdata[1:0];
                REG_FPS:  fps_reg    <= pwdata[7:0];
                REG_MIN:  min_reg    <= pwdata;
                REG_ACT:  active_reg <= pwdata[3:0];
                default:  ;
            endcase
        end
    end

    // configuration reads
    always_comb
    begin
        case (reg_idx)
            REG_MODE: prdata = APB_DW'(mode_reg);
            REG_FPS:  prdata = APB_DW'(fps_reg);
            REG_MIN:  prdata = min_reg;
            REG_ACT:  prdata = APB_DW'(active_reg);
            default:  prdata = '0;
        endcase
    end

    fbf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbf_dp #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_dp
    (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cmd                     (cmd),
        .stat                    (stat),
        .cfg_mode                (mode_reg),
        .cfg_fps                 (fps_reg),
        .cfg_min                 (min_reg),
        .cfg_active              (active_reg),
        .in_kind                 (in_ch.kind),
        .in_client_id            (in_ch.client_id),
        .in_frame_num            (in_ch.frame_num),
        .in_packet_bytes         (in_ch.packet_bytes),
        .in_cc_frame_bytes       (in_ch.cc_frame_bytes),
        .in_capacity_frame_bytes (in_ch.capacity_frame_bytes),
        .in_constrained          (in_ch.constrained),
        .in_downlink_rate_q8     (in_ch.downlink_rate_q8),
        .out_ready               (out_ch.ready),
        .out_valid               (out_ch.valid),
        .out_dest_id             (out_ch.dest_id),
        .out_forward             (out_ch.forward),
        .out_last                (out_ch.last)
    );
endmodule

>>> src/fbf_chk.sv
// Port-level checker for the filter, bound to the top level.
module fbf_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_kind,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_dest_id,
    input logic       out_forward,
    input logic       out_last
);
    // a stalled decision word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_dest_id)
            && $stable(out_forward) && $stable(out_last))
        else $error("decision word changed while stalled");

    // no new word is taken while a packet still has destinations pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input taken in the middle of a packet");

    // a client update produces no decision
    a_upd_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_kind && !out_valid |=> !out_valid)
        else $error("decision word after a client update");
endmodule

bind frame_budget_forward_filter_unit fbf_chk u_fbf_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_kind     (in_ch.kind),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_dest_id (out_ch.dest_id),
    .out_forward (out_ch.forward),
    .out_last    (out_ch.last)
);
